FILE: rtl/tle_pkg.sv
// Package: shared constants, codes and types of the terminal line editor.
`timescale 1ns / 1ps
package tle_pkg;

  localparam int LINE_LEN  = 16;
  localparam int IDX_W     = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam int CUR_W     = $clog2(LINE_LEN + 1);
  localparam int BYTE_W    = 8;
  localparam int ACT_W     = 2;
  localparam int RUN_W     = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_BYTE = 2'd0,
    ACT_BSB  = 2'd1,
    ACT_RUN  = 2'd2,
    ACT_END  = 2'd3
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 3'd3;

  localparam logic [BYTE_W-1:0] RST_ERASE = 8'd127;
  localparam logic [BYTE_W-1:0] RST_KILL  = 8'd21;
  localparam logic [BYTE_W-1:0] RST_WORD  = 8'd12;
  localparam logic [BYTE_W-1:0] RST_END   = 8'd4;

  localparam logic [BYTE_W-1:0] CH_BELL     = 8'd7;
  localparam logic [BYTE_W-1:0] CH_NL       = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR       = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'd32;
  localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'd126;

  typedef struct packed {
    logic [BYTE_W-1:0] erase;
    logic [BYTE_W-1:0] kill;
    logic [BYTE_W-1:0] word;
    logic [BYTE_W-1:0] eoi;
  } codes_t;

  typedef struct packed {
    logic              valid;
    action_t           action;
    logic [BYTE_W-1:0] chr;
    logic [RUN_W-1:0]  run;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic [CUR_W-1:0] cursor;
    logic             ended;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ONE,
    ST_NL,
    ST_KILL,
    ST_WSP,
    ST_WWD,
    ST_CR1,
    ST_SHOW1,
    ST_RUN,
    ST_CR2,
    ST_SHOW2
  } state_t;

endpackage

FILE: rtl/tle_line_ram.sv
// Line store: synchronous RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module tle_line_ram
  import tle_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [LINE_LEN];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/tle_ctrl.sv
// Sequencer: decodes a key, keeps cursor and end flag, walks the line store.
`timescale 1ns / 1ps
module tle_ctrl
  import tle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  codes_t            codes,
  input  logic              slot_free,
  output result_t           res,
  output ram_wr_t           ram_wr,
  output logic [IDX_W-1:0]  rd_addr,
  input  logic [BYTE_W-1:0] rd_data,
  output status_t           status
);

  state_t            state_r, state_nxt;
  logic [CUR_W-1:0]  cur_r, cur_nxt;
  logic [CUR_W-1:0]  idx_r, idx_nxt;
  logic              ended_r, ended_nxt;
  action_t           one_act_r, one_act_nxt;
  logic [BYTE_W-1:0] one_chr_r, one_chr_nxt;

  logic             in_fire;
  logic             take;
  logic             dec_end, dec_erase, dec_kill, dec_word, dec_print;
  logic             cur_zero, line_full, rd_space;
  logic [CUR_W-1:0] idx_inc;
  logic             idx_at_end;
  logic [CUR_W-1:0] run_len;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign take       = in_fire && !ended_r;
  assign cur_zero   = (cur_r == '0);
  assign line_full  = (cur_r >= CUR_W'(LINE_LEN));
  assign rd_space   = (rd_data == CH_SPACE);
  assign idx_inc    = idx_r + CUR_W'(1);
  assign idx_at_end = (idx_inc == cur_r);
  assign run_len    = CUR_W'(LINE_LEN) - cur_r;

  assign dec_end   = (in_byte == codes.eoi) && cur_zero;
  assign dec_erase = (in_byte == codes.erase);
  assign dec_kill  = (in_byte == codes.kill);
  assign dec_word  = (in_byte == codes.word);
  assign dec_print = (in_byte >= CH_PRINT_LO) && (in_byte <= CH_PRINT_HI);

  // read address tracks next index, so rd_data always belongs to idx_r
  assign rd_addr = idx_nxt[IDX_W-1:0];
  assign status  = '{cursor: cur_r, ended: ended_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (dec_end || dec_erase) begin
            state_nxt = ST_ONE;
          end else if (dec_kill) begin
            state_nxt = cur_zero ? ST_IDLE : ST_KILL;
          end else if (dec_word) begin
            state_nxt = ST_WSP;
          end else if (dec_print) begin
            state_nxt = line_full ? ST_NL : ST_ONE;
          end else begin
            state_nxt = ST_ONE;
          end
        end
      end
      ST_ONE:   if (slot_free) state_nxt = ST_IDLE;
      ST_NL:    if (slot_free) state_nxt = ST_ONE;
      ST_KILL:  if (slot_free && cur_r == CUR_W'(1)) state_nxt = ST_IDLE;
      ST_WSP: begin
        if (cur_zero) begin
          state_nxt = ST_CR1;
        end else if (!rd_space) begin
          state_nxt = ST_WWD;
        end
      end
      ST_WWD:   if (cur_zero || rd_space) state_nxt = ST_CR1;
      ST_CR1:   if (slot_free) state_nxt = cur_zero ? ST_RUN : ST_SHOW1;
      ST_SHOW1: if (slot_free && idx_at_end) state_nxt = ST_RUN;
      ST_RUN:   if (slot_free) state_nxt = ST_CR2;
      ST_CR2:   if (slot_free) state_nxt = cur_zero ? ST_IDLE : ST_SHOW2;
      ST_SHOW2: if (slot_free && idx_at_end) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt     = cur_r;
    idx_nxt     = idx_r;
    ended_nxt   = ended_r;
    one_act_nxt = one_act_r;
    one_chr_nxt = one_chr_r;
    res         = '0;
    res.action  = ACT_BYTE;
    ram_wr      = '0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          idx_nxt = cur_r - CUR_W'(1);
          if (dec_end) begin
            ended_nxt   = 1'b1;
            one_act_nxt = ACT_END;
            one_chr_nxt = '0;
          end else if (dec_erase) begin
            if (!cur_zero) begin
              cur_nxt     = cur_r - CUR_W'(1);
              one_act_nxt = ACT_BSB;
              one_chr_nxt = '0;
            end else begin
              one_act_nxt = ACT_BYTE;
              one_chr_nxt = CH_BELL;
            end
          end else if (dec_kill || dec_word) begin
            // handled by the walking states
          end else if (dec_print) begin
            ram_wr.we   = 1'b1;
            ram_wr.addr = line_full ? '0 : cur_r[IDX_W-1:0];
            ram_wr.data = in_byte;
            cur_nxt     = line_full ? CUR_W'(1) : cur_r + CUR_W'(1);
            one_act_nxt = ACT_BYTE;
            one_chr_nxt = in_byte;
          end else begin
            one_act_nxt = ACT_BYTE;
            one_chr_nxt = CH_BELL;
          end
        end
      end
      ST_ONE: begin
        if (slot_free) begin
          res.valid  = 1'b1;
          res.action = one_act_r;
          res.chr    = one_chr_r;
          res.last   = 1'b1;
        end
      end
      ST_NL: begin
        if (slot_free) begin
          res.valid = 1'b1;
          res.chr   = CH_NL;
        end
      end
      ST_KILL: begin
        if (slot_free) begin
          res.valid  = 1'b1;
          res.action = ACT_BSB;
          res.last   = (cur_r == CUR_W'(1));
          cur_nxt    = cur_r - CUR_W'(1);
        end
      end
      ST_WSP, ST_WWD: begin
        if (slot_free && !cur_zero && ((state_r == ST_WSP) == rd_space)) begin
          res.valid  = 1'b1;
          res.action = ACT_BSB;
          cur_nxt    = cur_r - CUR_W'(1);
          idx_nxt    = idx_r - CUR_W'(1);
        end
      end
      ST_CR1: begin
        idx_nxt = '0;
        if (slot_free) begin
          res.valid = 1'b1;
          res.chr   = CH_CR;
        end
      end
      ST_SHOW1, ST_SHOW2: begin
        if (slot_free) begin
          res.valid = 1'b1;
          res.chr   = rd_data;
          res.last  = (state_r == ST_SHOW2) && idx_at_end;
          idx_nxt   = idx_inc;
        end
      end
      ST_RUN: begin
        idx_nxt = '0;
        if (slot_free) begin
          res.valid  = 1'b1;
          res.action = ACT_RUN;
          res.run    = RUN_W'(run_len);
        end
      end
      ST_CR2: begin
        idx_nxt = '0;
        if (slot_free) begin
          res.valid = 1'b1;
          res.chr   = CH_CR;
          res.last  = cur_zero;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r   <= '0;
      ended_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      ended_r <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    one_act_r <= one_act_nxt;
    one_chr_r <= one_chr_nxt;
  end

endmodule

FILE: rtl/terminal_line_editor_unit.sv
// Top level: config registers, output register, sequencer and line store.
`timescale 1ns / 1ps
// Terminal line editor.
// Input channel (in_valid/in_ready, in_input_byte) takes one keyboard byte
// per item. Each byte that causes results gives a burst of display actions
// on the output channel (out_action, out_out_byte, out_run_length), the
// final one flagged by out_last. Some bytes give none (kill on an empty
// line, anything after end of input).
// Config port: cfg_we with cfg_index 0..3 writes erase, kill, word and end
// codes; other indexes are dropped. Write only while the block is idle.
// Timing: in_ready is high only while the sequencer is idle. An accepted
// item is decoded in the idle state; its first result is loaded into the
// output register from the next state, but for a word erase on an empty
// line or one ending in a word the space scan step gives no result first.
// With out_ready held high the results leave at one per cycle after the
// decode step. In a word erase, the step ending the space scan and, if a
// word was found, the step leaving the word scan give no result. The rate
// is set by the single output register and the one-read-per-cycle line RAM.
// Reset: cursor cleared, end flag cleared, codes back to 127/21/12/4. The
// line RAM is not cleared; only written entries are ever read.
// Stall: while out_ready is low and the output register is full, it holds
// its item and the sequencer waits in place, re-reading the same RAM entry.
module terminal_line_editor_unit
  import tle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_input_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ACT_W-1:0]     out_action,
  output logic [BYTE_W-1:0]    out_out_byte,
  output logic [RUN_W-1:0]     out_run_length,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  codes_t            codes_r, codes_nxt;
  result_t           res;
  ram_wr_t           ram_wr;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  status_t           status;
  logic              slot_free;

  logic              out_valid_r, out_valid_nxt;
  action_t           out_action_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [RUN_W-1:0]  out_run_r;
  logic              out_last_r;

  // config registers
  always_comb begin
    codes_nxt = codes_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ERASE: codes_nxt.erase = cfg_wdata;
        CFG_KILL:  codes_nxt.kill  = cfg_wdata;
        CFG_WORD:  codes_nxt.word  = cfg_wdata;
        CFG_END:   codes_nxt.eoi   = cfg_wdata;
        default:   codes_nxt       = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r <= '{erase: RST_ERASE, kill: RST_KILL, word: RST_WORD, eoi: RST_END};
    end else begin
      codes_r <= codes_nxt;
    end
  end

  // sequencer may load a new result when the register is empty or draining
  assign slot_free = !out_valid_r || out_ready;

  tle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_input_byte),
    .codes     (codes_r),
    .slot_free (slot_free),
    .res       (res),
    .ram_wr    (ram_wr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .status    (status)
  );

  tle_line_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_action_r <= res.action;
      out_byte_r   <= res.chr;
      out_run_r    <= res.run;
      out_last_r   <= res.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_out_byte   = out_byte_r;
  assign out_run_length = out_run_r;
  assign out_last       = out_last_r;

  // cursor never runs past the line
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.cursor <= CUR_W'(LINE_LEN))
    else $error("cursor beyond line length");

  // end of input is always a burst of its own
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_END) |-> out_last)
    else $error("end action without last mark");

  // once ended, accepted bytes cause nothing
  a_ended_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && status.ended) |=> !res.valid)
    else $error("result after end of input");

  // a new result is only loaded when the register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid || out_ready))
    else $error("output register overwritten");

endmodule
